@@ design/ccent_pkg.sv @@
// ----------------------------------------------------------------------------
// ccent_pkg
// Shared types and constants of the color ratio centroid block.
// ----------------------------------------------------------------------------
package ccent_pkg;

  localparam int FRAME_WIDTH_W     = 11;
  localparam int FRAME_WIDTH_RESET = 320;
  localparam int HIT_RATIO         = 5;
  localparam int COLOR_W           = 8;
  localparam int CENTROID_W        = 10;
  localparam int QUEUE_DEPTH       = 2;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last_pixel;
  } pixel_t;

  typedef struct packed {
    logic                  found;
    logic [CENTROID_W-1:0] centroid_x;
    logic [CENTROID_W-1:0] centroid_y;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_DONE
  } back_state_t;

endpackage

@@ design/ccent_front.sv @@
// ----------------------------------------------------------------------------
// ccent_front
// Pixel front end: tracks column and row, tests color, accumulates sums and
// pushes frame totals into the queue on the last pixel.
// ----------------------------------------------------------------------------
module ccent_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [ccent_pkg::FRAME_WIDTH_W-1:0]   cfg_data,
  input  logic                                  pix_valid,
  input  ccent_pkg::pixel_t                     pix_data,
  input  logic                                  q_full,
  output logic                                  pix_ready,
  output logic                                  push,
  output logic [2*(((MAX_WIDTH > MAX_HEIGHT) ? $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT))
                 + $clog2(MAX_WIDTH*MAX_HEIGHT+1))
                 + $clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] push_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int QW   = (CW > RW) ? CW : RW;
  localparam int CAP  = MAX_WIDTH * MAX_HEIGHT;
  localparam int NW   = $clog2(CAP + 1);
  localparam int SW   = QW + NW;
  localparam int MW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (ccent_pkg::FRAME_WIDTH_W > MW) ? ccent_pkg::FRAME_WIDTH_W : MW;
  localparam int PW   = ccent_pkg::COLOR_W + 3;

  logic [ccent_pkg::FRAME_WIDTH_W-1:0] fw_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [SW-1:0] sx_r, sx_nxt, sx_sum;
  logic [SW-1:0] sy_r, sy_nxt, sy_sum;
  logic [NW-1:0] cnt_r, cnt_nxt, cnt_sum;
  logic [CMPW-1:0] fw_ext, eff_w;
  logic hit, accept;

  assign pix_ready = !q_full;
  assign accept    = pix_valid && pix_ready;

  always_comb begin
    fw_ext = CMPW'(fw_r);
    if (fw_ext == '0) begin
      eff_w = CMPW'(1);
    end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
      eff_w = CMPW'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end

    hit = (PW'(pix_data.blue) > PW'(pix_data.red) * PW'(ccent_pkg::HIT_RATIO))
       && (PW'(pix_data.blue) > PW'(pix_data.green) * PW'(ccent_pkg::HIT_RATIO))
       && (cnt_r < NW'(CAP));

    sx_sum  = hit ? sx_r + SW'(col_r) : sx_r;
    sy_sum  = hit ? sy_r + SW'(row_r) : sy_r;
    cnt_sum = hit ? cnt_r + NW'(1) : cnt_r;

    push      = accept && pix_data.last_pixel;
    push_data = {sx_sum, sy_sum, cnt_sum};

    col_nxt = col_r;
    row_nxt = row_r;
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (pix_data.last_pixel) begin
        col_nxt = '0;
        row_nxt = '0;
        sx_nxt  = '0;
        sy_nxt  = '0;
        cnt_nxt = '0;
      end else begin
        sx_nxt  = sx_sum;
        sy_nxt  = sy_sum;
        cnt_nxt = cnt_sum;
        if (CMPW'(col_r) + CMPW'(1) >= eff_w) begin
          col_nxt = '0;
          if (row_r != RW'(MAX_HEIGHT - 1)) begin
            row_nxt = row_r + RW'(1);
          end
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= ccent_pkg::FRAME_WIDTH_W'(ccent_pkg::FRAME_WIDTH_RESET);
      col_r <= '0;
      row_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        fw_r <= cfg_data;
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ design/ccent_queue.sv @@
// ----------------------------------------------------------------------------
// ccent_queue
// Short FIFO of frame totals between the pixel front end and the divider.
// ----------------------------------------------------------------------------
module ccent_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);

  localparam int AW = (ccent_pkg::QUEUE_DEPTH > 1) ? $clog2(ccent_pkg::QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(ccent_pkg::QUEUE_DEPTH + 1);

  logic [W-1:0]  mem_r [ccent_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;

  assign full     = (count_r == NW'(ccent_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(ccent_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(ccent_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + NW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

endmodule

@@ design/ccent_back.sv @@
// ----------------------------------------------------------------------------
// ccent_back
// Frame back end: restoring divider for both means, one quotient bit per
// cycle, feeding a result output register.
// ----------------------------------------------------------------------------
module ccent_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  logic [2*(((MAX_WIDTH > MAX_HEIGHT) ? $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT))
                 + $clog2(MAX_WIDTH*MAX_HEIGHT+1))
                 + $clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] q_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output ccent_pkg::result_t  out_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int QW  = (CW > RW) ? CW : RW;
  localparam int CAP = MAX_WIDTH * MAX_HEIGHT;
  localparam int NW  = $clog2(CAP + 1);
  localparam int SW  = QW + NW;
  localparam int KW  = $clog2(QW + 1);

  ccent_pkg::back_state_t state_r, state_nxt;

  logic [SW-1:0] q_sx, q_sy;
  logic [NW-1:0] q_cnt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] lo_r, lo_nxt;
  logic [NW-1:0] div_r, div_nxt;
  logic [SW-1:0] sy_r, sy_nxt;
  logic [QW-1:0] qx_r, qx_nxt;
  logic [KW-1:0] step_r, step_nxt;
  logic          found_r, found_nxt;
  logic          out_valid_r, out_valid_nxt;
  ccent_pkg::result_t out_r, out_nxt;
  logic [NW:0]   trial;
  logic          qbit, last_step;

  assign {q_sx, q_sy, q_cnt} = q_data;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ccent_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    lo_r    <= lo_nxt;
    div_r   <= div_nxt;
    sy_r    <= sy_nxt;
    qx_r    <= qx_nxt;
    step_r  <= step_nxt;
    found_r <= found_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    trial     = {rem_r, lo_r[QW-1]};
    qbit      = (trial >= {1'b0, div_r});
    last_step = (step_r == KW'(QW - 1));

    state_nxt     = state_r;
    pop           = 1'b0;
    rem_nxt       = rem_r;
    lo_nxt        = lo_r;
    div_nxt       = div_r;
    sy_nxt        = sy_r;
    qx_nxt        = qx_r;
    step_nxt      = step_r;
    found_nxt     = found_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      ccent_pkg::ST_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          rem_nxt   = q_sx[SW-1:QW];
          lo_nxt    = q_sx[QW-1:0];
          div_nxt   = q_cnt;
          sy_nxt    = q_sy;
          step_nxt  = '0;
          found_nxt = (q_cnt != '0);
          qx_nxt    = '0;
          state_nxt = (q_cnt != '0) ? ccent_pkg::ST_DIV_X : ccent_pkg::ST_DONE;
          if (q_cnt == '0) begin
            lo_nxt = '0;
          end
        end
      end
      ccent_pkg::ST_DIV_X, ccent_pkg::ST_DIV_Y: begin
        rem_nxt  = qbit ? NW'(trial - {1'b0, div_r}) : NW'(trial);
        lo_nxt   = (lo_r << 1) | QW'(qbit);
        step_nxt = step_r + KW'(1);
        if (last_step) begin
          step_nxt = '0;
          if (state_r == ccent_pkg::ST_DIV_X) begin
            qx_nxt    = (lo_r << 1) | QW'(qbit);
            rem_nxt   = sy_r[SW-1:QW];
            lo_nxt    = sy_r[QW-1:0];
            state_nxt = ccent_pkg::ST_DIV_Y;
          end else begin
            state_nxt = ccent_pkg::ST_DONE;
          end
        end
      end
      ccent_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.found      = found_r;
          out_nxt.centroid_x = ccent_pkg::CENTROID_W'(qx_r);
          out_nxt.centroid_y = ccent_pkg::CENTROID_W'(lo_r);
          out_valid_nxt      = 1'b1;
          state_nxt          = ccent_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ccent_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/color_ratio_centroid.sv @@
// ----------------------------------------------------------------------------
// color_ratio_centroid
// Centroid of strongly blue pixels in a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one RGB pixel per item in raster order,
//   last_pixel marking the end of a frame. Column and row are counted here,
//   the column wrapping at frame_width (cfg_we/cfg_data, reset 320).
//   One pixel is taken every cycle; in_ready drops only while both frame
//   slots of the two-entry totals queue are occupied.
//   out_valid/out_ready/out_data carry one result per frame: found and the
//   truncated mean column and row of the hits.
//   Totals pass through the queue, then the bit-serial divider (quotient
//   width Q: the larger of log2 MAX_WIDTH and log2 MAX_HEIGHT, 10 by
//   default), then the result register; a frame without hits skips the divider.
//   The divider works while the next frame streams in, so a frame needs at
//   least 2*Q+2 pixels to keep full pixel rate.
//   A stalled receiver holds the result register; the divider then waits
//   and frames collect in the queue until in_ready drops.
//   Reset (rst_n low, synchronous) clears the pixel counters and sums, the
//   queue and out_valid, idles the divider and restores frame_width to 320.
// ----------------------------------------------------------------------------
module color_ratio_centroid #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ccent_pkg::FRAME_WIDTH_W-1:0] cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ccent_pkg::pixel_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ccent_pkg::result_t                  out_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int QW  = (CW > RW) ? CW : RW;
  localparam int NW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int EW  = 2 * (QW + NW) + NW;

  logic          push, pop, q_full, q_empty;
  logic [EW-1:0] push_data, pop_data;

  ccent_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .pix_valid (in_valid),
    .pix_data  (in_data),
    .q_full    (q_full),
    .pix_ready (in_ready),
    .push      (push),
    .push_data (push_data)
  );

  ccent_queue #(
    .W (EW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  ccent_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("totals pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("totals popped from an empty queue");

  a_empty_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |->
      (out_data.centroid_x == '0 && out_data.centroid_y == '0))
    else $error("frame without hits reports a nonzero centroid");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_valid && in_ready))
    else $error("block not empty after reset");

endmodule

@@ tb/sv/color_ratio_centroid_checker.sv @@
// ----------------------------------------------------------------------------
// color_ratio_centroid_checker
// Watches the pixel, result and configuration ports of the centroid block,
// tracks column, row, hit sums and hit count per frame, and compares every
// result item against the centroid predicted for the oldest closed frame.
// ----------------------------------------------------------------------------
module color_ratio_centroid_checker
  import ccent_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [FRAME_WIDTH_W-1:0] cfg_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  pixel_t                   in_data,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  result_t                  out_data,
  output int                       fail_count,
  output int                       pending
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIT_CAP = MAX_WIDTH * MAX_HEIGHT;

  logic [FRAME_WIDTH_W-1:0] width_reg;
  logic [CENTROID_W-1:0]    col_pos;
  logic [CENTROID_W-1:0]    row_pos;
  logic [29:0]              sum_x;
  logic [29:0]              sum_y;
  logic [20:0]              hit_total;
  result_t                  centroid_q[$];

  function automatic int active_width(input logic [FRAME_WIDTH_W-1:0] w);
    if (w == 0) return 1;
    if (int'(w) > MAX_WIDTH) return MAX_WIDTH;
    return int'(w);
  endfunction

  task automatic clear_frame_totals();
    col_pos   = '0;
    row_pos   = '0;
    sum_x     = '0;
    sum_y     = '0;
    hit_total = '0;
  endtask

  task automatic absorb_pixel(input pixel_t px);
    int      w;
    bit      is_hit;
    result_t res;
    w = active_width(width_reg);
    is_hit = (int'(px.blue) > HIT_RATIO * int'(px.red)) &&
             (int'(px.blue) > HIT_RATIO * int'(px.green));
    if (is_hit && int'(hit_total) < HIT_CAP) begin
      sum_x     = sum_x + 30'(col_pos);
      sum_y     = sum_y + 30'(row_pos);
      hit_total = hit_total + 21'd1;
    end
    if (int'(col_pos) + 1 >= w) begin
      col_pos = '0;
      if (int'(row_pos) + 1 < MAX_HEIGHT) row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    if (px.last_pixel) begin
      res = '0;
      if (hit_total != 0) begin
        res.found      = 1'b1;
        res.centroid_x = CENTROID_W'(sum_x / 30'(hit_total));
        res.centroid_y = CENTROID_W'(sum_y / 30'(hit_total));
      end
      centroid_q.push_back(res);
      clear_frame_totals();
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      width_reg = FRAME_WIDTH_W'(FRAME_WIDTH_RESET);
      clear_frame_totals();
      centroid_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (centroid_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result item, expected none, got found=%0d x=%0d y=%0d",
                   $time, out_data.found, out_data.centroid_x, out_data.centroid_y);
        end else begin
          want = centroid_q.pop_front();
          if (want.found !== out_data.found || want.centroid_x !== out_data.centroid_x ||
              want.centroid_y !== out_data.centroid_y) begin
            fail_count++;
            $display("%0t: centroid mismatch, expected found=%0d x=%0d y=%0d, got found=%0d x=%0d y=%0d",
                     $time, want.found, want.centroid_x, want.centroid_y,
                     out_data.found, out_data.centroid_x, out_data.centroid_y);
          end
        end
      end
      if (cfg_we) width_reg = cfg_data;
      if (in_valid && in_ready) absorb_pixel(in_data);
    end
    pending = centroid_q.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives pixel frames into the color ratio centroid block under several frame
// widths: directed color-ratio edges, width clamping and a mid-row width
// change, then random frames with bursty input and a stalling receiver, then
// row saturation. The checker predicts and compares each result item.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import ccent_pkg::*;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 55;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [FRAME_WIDTH_W-1:0] cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  pixel_t                   in_data;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  result_t                  out_data;
  int                       fail_count;
  int                       pending;

  bit idle_on;
  int stall_mode;
  int burst_left;
  int stall_left;

  color_ratio_centroid #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  color_ratio_centroid_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    if (stall_mode == 0) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 20);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic pixel_t pix(input int r, input int g, input int b, input bit last);
    pixel_t px;
    px.red        = COLOR_W'(r);
    px.green      = COLOR_W'(g);
    px.blue       = COLOR_W'(b);
    px.last_pixel = last;
    return px;
  endfunction

  function automatic pixel_t make_pixel(input int hit_pct);
    pixel_t px;
    int     bound;
    if ($urandom_range(0, 99) < hit_pct) begin
      px.red   = COLOR_W'($urandom_range(0, 51));
      px.green = COLOR_W'($urandom_range(0, 51));
      bound    = HIT_RATIO * ((px.red > px.green) ? int'(px.red) : int'(px.green));
      if (bound < 255 && $urandom_range(0, 5) != 0) begin
        px.blue = COLOR_W'($urandom_range(bound + 1, 255));
      end else if (bound <= 255) begin
        px.blue = COLOR_W'(bound);
      end else begin
        px.blue = COLOR_W'($urandom);
      end
    end else begin
      px.red   = COLOR_W'($urandom);
      px.green = COLOR_W'($urandom);
      px.blue  = COLOR_W'($urandom);
    end
    px.last_pixel = 1'b0;
    return px;
  endfunction

  task automatic send_pixel(input pixel_t px);
    if (idle_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_frame(input int len, input int hit_pct, input bit close);
    pixel_t px;
    for (int i = 0; i < len; i++) begin
      px = make_pixel(hit_pct);
      px.last_pixel = close && (i == len - 1);
      send_pixel(px);
    end
  endtask

  // hold input until every result is back and the block has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_width(input int w);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= FRAME_WIDTH_W'(w);
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic run_phase(input int budget);
    int sent;
    int len;
    int sel;
    sent = 0;
    while (sent < budget) begin
      sel = $urandom_range(0, 19);
      if (sel < 2) len = 1;
      else if (sel < 16) len = $urandom_range(2, 30);
      else len = $urandom_range(31, 120);
      send_frame(len, $urandom_range(0, 90), 1'b1);
      sent += len;
    end
    if ($urandom_range(0, 2) == 0) send_frame($urandom_range(1, 10), 50, 1'b0);
  endtask

  initial begin
    int widths[12];
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    idle_on    = 1'b0;
    stall_mode = 0;
    burst_left = 0;
    stall_left = 0;
    widths = '{1, 2, 3, 5, 7, 16, 33, 1024, 0, 2047, 1023, 1025};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_pixel(pix(0, 0, 255, 1'b1));
    send_pixel(pix(255, 255, 255, 1'b1));
    send_pixel(pix(51, 0, 255, 1'b0));
    send_pixel(pix(0, 51, 255, 1'b0));
    send_pixel(pix(50, 50, 251, 1'b0));
    send_pixel(pix(0, 0, 0, 1'b0));
    send_pixel(pix(0, 0, 1, 1'b1));
    write_width(0);
    for (int i = 0; i < 4; i++) send_pixel(pix(0, 0, 200, i == 3));
    write_width(2047);
    for (int i = 0; i < 3; i++) send_pixel(pix(1, 2, 128, i == 2));
    write_width(1024);
    send_pixel(pix(255, 0, 255, 1'b1));
    write_width(8);
    for (int i = 0; i < 6; i++) send_pixel(pix(200, 100, 50, 1'b0));
    write_width(4);
    send_pixel(pix(0, 0, 255, 1'b0));
    send_pixel(pix(0, 0, 255, 1'b1));

    for (int p = 0; p < 13; p++) begin
      write_width((p < 12) ? widths[p] : $urandom_range(0, 2047));
      idle_on    = (p % 4 != 3);
      stall_mode = (p % 4 == 1 || p % 4 == 3) ? 0 : 1;
      run_phase(PHASE_ITEMS);
    end

    write_width(1);
    idle_on    = 1'b1;
    stall_mode = 1;
    send_frame(MAX_HEIGHT + 6, 50, 1'b1);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
